### src/aesr_pkg.sv
// Package with the AES S-box, GF(2^8) helpers and shared constants.
`timescale 1ns / 1ps
package aesr_pkg;

   localparam int unsigned NumLanes = 4;
   localparam logic [7:0] GfReduce = 8'h1b;

   typedef logic [7:0] byte_type;
   typedef logic [31:0] column_type;

   function automatic byte_type sbox(input byte_type a);
      byte_type r;
      unique case (a)
         8'h00: r = 8'h63; 8'h01: r = 8'h7c; 8'h02: r = 8'h77; 8'h03: r = 8'h7b;
         8'h04: r = 8'hf2; 8'h05: r = 8'h6b; 8'h06: r = 8'h6f; 8'h07: r = 8'hc5;
         8'h08: r = 8'h30; 8'h09: r = 8'h01; 8'h0a: r = 8'h67; 8'h0b: r = 8'h2b;
         8'h0c: r = 8'hfe; 8'h0d: r = 8'hd7; 8'h0e: r = 8'hab; 8'h0f: r = 8'h76;
         8'h10: r = 8'hca; 8'h11: r = 8'h82; 8'h12: r = 8'hc9; 8'h13: r = 8'h7d;
         8'h14: r = 8'hfa; 8'h15: r = 8'h59; 8'h16: r = 8'h47; 8'h17: r = 8'hf0;
         8'h18: r = 8'had; 8'h19: r = 8'hd4; 8'h1a: r = 8'ha2; 8'h1b: r = 8'haf;
         8'h1c: r = 8'h9c; 8'h1d: r = 8'ha4; 8'h1e: r = 8'h72; 8'h1f: r = 8'hc0;
         8'h20: r = 8'hb7; 8'h21: r = 8'hfd; 8'h22: r = 8'h93; 8'h23: r = 8'h26;
         8'h24: r = 8'h36; 8'h25: r = 8'h3f; 8'h26: r = 8'hf7; 8'h27: r = 8'hcc;
         8'h28: r = 8'h34; 8'h29: r = 8'ha5; 8'h2a: r = 8'he5; 8'h2b: r = 8'hf1;
         8'h2c: r = 8'h71; 8'h2d: r = 8'hd8; 8'h2e: r = 8'h31; 8'h2f: r = 8'h15;
         8'h30: r = 8'h04; 8'h31: r = 8'hc7; 8'h32: r = 8'h23; 8'h33: r = 8'hc3;
         8'h34: r = 8'h18; 8'h35: r = 8'h96; 8'h36: r = 8'h05; 8'h37: r = 8'h9a;
         8'h38: r = 8'h07; 8'h39: r = 8'h12; 8'h3a: r = 8'h80; 8'h3b: r = 8'he2;
         8'h3c: r = 8'heb; 8'h3d: r = 8'h27; 8'h3e: r = 8'hb2; 8'h3f: r = 8'h75;
         8'h40: r = 8'h09; 8'h41: r = 8'h83; 8'h42: r = 8'h2c; 8'h43: r = 8'h1a;
         8'h44: r = 8'h1b; 8'h45: r = 8'h6e; 8'h46: r = 8'h5a; 8'h47: r = 8'ha0;
         8'h48: r = 8'h52; 8'h49: r = 8'h3b; 8'h4a: r = 8'hd6; 8'h4b: r = 8'hb3;
         8'h4c: r = 8'h29; 8'h4d: r = 8'he3; 8'h4e: r = 8'h2f; 8'h4f: r = 8'h84;
         8'h50: r = 8'h53; 8'h51: r = 8'hd1; 8'h52: r = 8'h00; 8'h53: r = 8'hed;
         8'h54: r = 8'h20; 8'h55: r = 8'hfc; 8'h56: r = 8'hb1; 8'h57: r = 8'h5b;
         8'h58: r = 8'h6a; 8'h59: r = 8'hcb; 8'h5a: r = 8'hbe; 8'h5b: r = 8'h39;
         8'h5c: r = 8'h4a; 8'h5d: r = 8'h4c; 8'h5e: r = 8'h58; 8'h5f: r = 8'hcf;
         8'h60: r = 8'hd0; 8'h61: r = 8'hef; 8'h62: r = 8'haa; 8'h63: r = 8'hfb;
         8'h64: r = 8'h43; 8'h65: r = 8'h4d; 8'h66: r = 8'h33; 8'h67: r = 8'h85;
         8'h68: r = 8'h45; 8'h69: r = 8'hf9; 8'h6a: r = 8'h02; 8'h6b: r = 8'h7f;
         8'h6c: r = 8'h50; 8'h6d: r = 8'h3c; 8'h6e: r = 8'h9f; 8'h6f: r = 8'ha8;
         8'h70: r = 8'h51; 8'h71: r = 8'ha3; 8'h72: r = 8'h40; 8'h73: r = 8'h8f;
         8'h74: r = 8'h92; 8'h75: r = 8'h9d; 8'h76: r = 8'h38; 8'h77: r = 8'hf5;
         8'h78: r = 8'hbc; 8'h79: r = 8'hb6; 8'h7a: r = 8'hda; 8'h7b: r = 8'h21;
         8'h7c: r = 8'h10; 8'h7d: r = 8'hff; 8'h7e: r = 8'hf3; 8'h7f: r = 8'hd2;
         8'h80: r = 8'hcd; 8'h81: r = 8'h0c; 8'h82: r = 8'h13; 8'h83: r = 8'hec;
         8'h84: r = 8'h5f; 8'h85: r = 8'h97; 8'h86: r = 8'h44; 8'h87: r = 8'h17;
         8'h88: r = 8'hc4; 8'h89: r = 8'ha7; 8'h8a: r = 8'h7e; 8'h8b: r = 8'h3d;
         8'h8c: r = 8'h64; 8'h8d: r = 8'h5d; 8'h8e: r = 8'h19; 8'h8f: r = 8'h73;
         8'h90: r = 8'h60; 8'h91: r = 8'h81; 8'h92: r = 8'h4f; 8'h93: r = 8'hdc;
         8'h94: r = 8'h22; 8'h95: r = 8'h2a; 8'h96: r = 8'h90; 8'h97: r = 8'h88;
         8'h98: r = 8'h46; 8'h99: r = 8'hee; 8'h9a: r = 8'hb8; 8'h9b: r = 8'h14;
         8'h9c: r = 8'hde; 8'h9d: r = 8'h5e; 8'h9e: r = 8'h0b; 8'h9f: r = 8'hdb;
         8'ha0: r = 8'he0; 8'ha1: r = 8'h32; 8'ha2: r = 8'h3a; 8'ha3: r = 8'h0a;
         8'ha4: r = 8'h49; 8'ha5: r = 8'h06; 8'ha6: r = 8'h24; 8'ha7: r = 8'h5c;
         8'ha8: r = 8'hc2; 8'ha9: r = 8'hd3; 8'haa: r = 8'hac; 8'hab: r = 8'h62;
         8'hac: r = 8'h91; 8'had: r = 8'h95; 8'hae: r = 8'he4; 8'haf: r = 8'h79;
         8'hb0: r = 8'he7; 8'hb1: r = 8'hc8; 8'hb2: r = 8'h37; 8'hb3: r = 8'h6d;
         8'hb4: r = 8'h8d; 8'hb5: r = 8'hd5; 8'hb6: r = 8'h4e; 8'hb7: r = 8'ha9;
         8'hb8: r = 8'h6c; 8'hb9: r = 8'h56; 8'hba: r = 8'hf4; 8'hbb: r = 8'hea;
         8'hbc: r = 8'h65; 8'hbd: r = 8'h7a; 8'hbe: r = 8'hae; 8'hbf: r = 8'h08;
         8'hc0: r = 8'hba; 8'hc1: r = 8'h78; 8'hc2: r = 8'h25; 8'hc3: r = 8'h2e;
         8'hc4: r = 8'h1c; 8'hc5: r = 8'ha6; 8'hc6: r = 8'hb4; 8'hc7: r = 8'hc6;
         8'hc8: r = 8'he8; 8'hc9: r = 8'hdd; 8'hca: r = 8'h74; 8'hcb: r = 8'h1f;
         8'hcc: r = 8'h4b; 8'hcd: r = 8'hbd; 8'hce: r = 8'h8b; 8'hcf: r = 8'h8a;
         8'hd0: r = 8'h70; 8'hd1: r = 8'h3e; 8'hd2: r = 8'hb5; 8'hd3: r = 8'h66;
         8'hd4: r = 8'h48; 8'hd5: r = 8'h03; 8'hd6: r = 8'hf6; 8'hd7: r = 8'h0e;
         8'hd8: r = 8'h61; 8'hd9: r = 8'h35; 8'hda: r = 8'h57; 8'hdb: r = 8'hb9;
         8'hdc: r = 8'h86; 8'hdd: r = 8'hc1; 8'hde: r = 8'h1d; 8'hdf: r = 8'h9e;
         8'he0: r = 8'he1; 8'he1: r = 8'hf8; 8'he2: r = 8'h98; 8'he3: r = 8'h11;
         8'he4: r = 8'h69; 8'he5: r = 8'hd9; 8'he6: r = 8'h8e; 8'he7: r = 8'h94;
         8'he8: r = 8'h9b; 8'he9: r = 8'h1e; 8'hea: r = 8'h87; 8'heb: r = 8'he9;
         8'hec: r = 8'hce; 8'hed: r = 8'h55; 8'hee: r = 8'h28; 8'hef: r = 8'hdf;
         8'hf0: r = 8'h8c; 8'hf1: r = 8'ha1; 8'hf2: r = 8'h89; 8'hf3: r = 8'h0d;
         8'hf4: r = 8'hbf; 8'hf5: r = 8'he6; 8'hf6: r = 8'h42; 8'hf7: r = 8'h68;
         8'hf8: r = 8'h41; 8'hf9: r = 8'h99; 8'hfa: r = 8'h2d; 8'hfb: r = 8'h0f;
         8'hfc: r = 8'hb0; 8'hfd: r = 8'h54; 8'hfe: r = 8'hbb; 8'hff: r = 8'h16;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic byte_type gf_double(input byte_type a);
      return {a[6:0], 1'b0} ^ (a[7] ? GfReduce : 8'h00);
   endfunction

endpackage

### src/aesr_lane.sv
// One column lane: S-box on four shifted bytes, MixColumns and round key add.
`timescale 1ns / 1ps
module aesr_lane (
   input  aesr_pkg::column_type col_in,
   input  aesr_pkg::column_type key_in,
   output aesr_pkg::column_type col_out
);

   aesr_pkg::byte_type a0, a1, a2, a3, d0, d1, d2, d3;

   always_comb begin
      a0 = aesr_pkg::sbox(col_in[31:24]);
      a1 = aesr_pkg::sbox(col_in[23:16]);
      a2 = aesr_pkg::sbox(col_in[15:8]);
      a3 = aesr_pkg::sbox(col_in[7:0]);
      d0 = aesr_pkg::gf_double(a0);
      d1 = aesr_pkg::gf_double(a1);
      d2 = aesr_pkg::gf_double(a2);
      d3 = aesr_pkg::gf_double(a3);
      col_out = {d0 ^ d1 ^ a1 ^ a2 ^ a3,
                 a0 ^ d1 ^ d2 ^ a2 ^ a3,
                 a0 ^ a1 ^ d2 ^ d3 ^ a3,
                 d0 ^ a0 ^ a1 ^ a2 ^ d3} ^ key_in;
   end

endmodule

### src/aes_encrypt_round.sv
// Top level of the single AES encryption round with a registered output stage.
`timescale 1ns / 1ps
// One AES encryption round (SubBytes, ShiftRows, MixColumns, AddRoundKey) per item.
// Four column lanes work in parallel and their columns merge into one output register,
// so one item is accepted every cycle unless the output stalls; its result is valid in
// the next cycle, and req_ready drops only while a result is held and rsp_ready is low.
module aes_encrypt_round (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_state_hi,
   input  logic [63:0] req_state_lo,
   input  logic [63:0] req_round_key_hi,
   input  logic [63:0] req_round_key_lo,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_result_hi,
   output logic [63:0] rsp_result_lo
);

   logic [127:0] state_w, key_w, merged_w;
   aesr_pkg::byte_type st_b [16];
   aesr_pkg::column_type lane_in [aesr_pkg::NumLanes];
   aesr_pkg::column_type lane_out [aesr_pkg::NumLanes];
   logic         valid_ff, valid_in;
   logic [127:0] data_ff;

   assign state_w = {req_state_hi, req_state_lo};
   assign key_w = {req_round_key_hi, req_round_key_lo};

   always_comb begin
      for (int n = 0; n < 16; n++) begin
         st_b[n] = state_w[127 - 8*n -: 8];
      end
      for (int c = 0; c < 4; c++) begin
         lane_in[c] = {st_b[4*((c + 0) % 4) + 0], st_b[4*((c + 1) % 4) + 1],
                       st_b[4*((c + 2) % 4) + 2], st_b[4*((c + 3) % 4) + 3]};
      end
   end

   for (genvar g = 0; g < aesr_pkg::NumLanes; g++) begin : g_lane
      aesr_lane u_lane (
         .col_in (lane_in[g]),
         .key_in (key_w[127 - 32*g -: 32]),
         .col_out(lane_out[g])
      );
   end

   assign merged_w = {lane_out[0], lane_out[1], lane_out[2], lane_out[3]};

   assign req_ready = !valid_ff || rsp_ready;
   assign valid_in = req_valid || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_ready) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         data_ff <= merged_w;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_result_hi = data_ff[127:64];
   assign rsp_result_lo = data_ff[63:0];

endmodule

### verif/aes_encrypt_round_test.sv
// Self-checking testbench for the single AES encryption round block.
`timescale 1ns / 1ps
module aes_encrypt_round_test;

   typedef struct packed {
      logic [63:0] hi;
      logic [63:0] lo;
   } block_type;

   class round_scoreboard;
      block_type expected_rounds[$];
      int errors;

      function new();
         errors = 0;
      endfunction

      function logic [7:0] xtime(logic [7:0] a);
         return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
      endfunction

      function logic [7:0] sub_byte(logic [7:0] a);
         logic [7:0] tab [256];
         tab = '{
            8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,
            8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
            8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,
            8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
            8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,
            8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
            8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,
            8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
            8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,
            8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
            8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,
            8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
            8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,
            8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
            8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,
            8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
            8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,
            8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
            8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,
            8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
            8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,
            8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
            8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,
            8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
            8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,
            8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
            8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,
            8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
            8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,
            8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
            8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,
            8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
         return tab[a];
      endfunction

      function block_type encrypt_round(block_type st, block_type rk);
         logic [127:0] s, k, out;
         logic [7:0] sh [16];
         logic [7:0] a0, a1, a2, a3;
         s = {st.hi, st.lo};
         k = {rk.hi, rk.lo};
         for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
               sh[4*c+r] = sub_byte(s[127 - 8*(4*((c+r)%4)+r) -: 8]);
         for (int c = 0; c < 4; c++) begin
            a0 = sh[4*c]; a1 = sh[4*c+1]; a2 = sh[4*c+2]; a3 = sh[4*c+3];
            out[127 - 8*(4*c) -: 8]   = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
            out[127 - 8*(4*c+1) -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
            out[127 - 8*(4*c+2) -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
            out[127 - 8*(4*c+3) -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
         end
         out = out ^ k;
         return {out[127:64], out[63:0]};
      endfunction

      function void note_round(block_type st, block_type rk);
         expected_rounds.push_back(encrypt_round(st, rk));
      endfunction

      function void check_result(block_type got);
         block_type want;
         if (expected_rounds.size() == 0) begin
            $display("%0t: unexpected result expected none actual %h_%h", $time, got.hi, got.lo);
            errors++;
            return;
         end
         want = expected_rounds.pop_front();
         if (got.hi !== want.hi) begin
            $display("%0t: result_hi expected %h actual %h", $time, want.hi, got.hi);
            errors++;
         end
         if (got.lo !== want.lo) begin
            $display("%0t: result_lo expected %h actual %h", $time, want.lo, got.lo);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [63:0] req_state_hi = '0;
   logic [63:0] req_state_lo = '0;
   logic [63:0] req_round_key_hi = '0;
   logic [63:0] req_round_key_lo = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [63:0] rsp_result_hi;
   logic [63:0] rsp_result_lo;

   round_scoreboard board = new();
   int send_idle_pct = 0;
   int stall_pct = 0;
   bit hold_off = 1'b0;
   int quiet_cycles = 0;

   aes_encrypt_round u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_state_hi(req_state_hi),
      .req_state_lo(req_state_lo),
      .req_round_key_hi(req_round_key_hi),
      .req_round_key_lo(req_round_key_lo),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_result_hi(rsp_result_hi),
      .rsp_result_lo(rsp_result_lo)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            board.note_round({req_state_hi, req_state_lo},
               {req_round_key_hi, req_round_key_lo});
         if (rsp_valid && rsp_ready)
            board.check_result({rsp_result_hi, rsp_result_lo});
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles > 3000) begin
            $display("** aes_encrypt_round: FAILED **");
            $finish;
         end
      end
   end

   always @(negedge clock) begin
      if (reset || hold_off)
         rsp_ready <= 1'b0;
      else
         rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic send_round(logic [63:0] sh, logic [63:0] sl, logic [63:0] kh,
                             logic [63:0] kl);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_state_hi <= sh;
      req_state_lo <= sl;
      req_round_key_hi <= kh;
      req_round_key_lo <= kl;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic random_rounds(int count);
      for (int i = 0; i < count; i++)
         send_round(rand64(), rand64(), rand64(), rand64());
   endtask

   initial begin
      int wait_count;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      send_round('0, '0, '0, '0);
      send_round('1, '1, '1, '1);
      send_round('1, '1, '0, '0);
      send_round('0, '0, '1, '1);
      send_round(64'h00112233_44556677, 64'h8899aabb_ccddeeff, '0, '0);
      send_round(64'h80808080_80808080, 64'h80808080_80808080, '0, '0);
      send_round(64'h7f7f7f7f_7f7f7f7f, 64'h7f7f7f7f_7f7f7f7f, 64'haaaaaaaa_aaaaaaaa,
                 64'h55555555_55555555);
      send_round(64'h01020304_05060708, 64'h090a0b0c_0d0e0f10, 64'h55555555_55555555,
                 64'haaaaaaaa_aaaaaaaa);
      for (int b = 0; b < 16; b++)
         send_round(64'h1 << (4 * b), ~(64'h1 << (4 * b)), rand64(), rand64());
      random_rounds(300);
      send_idle_pct = 58;
      random_rounds(300);
      send_idle_pct = 0;
      stall_pct = 58;
      random_rounds(300);
      send_idle_pct = 22;
      stall_pct = 22;
      random_rounds(300);
      send_idle_pct = 0;
      stall_pct = 0;
      hold_off = 1'b1;
      fork
         begin
            repeat (60) @(negedge clock);
            hold_off = 1'b0;
         end
         begin
            random_rounds(176);
            req_valid <= 1'b0;
         end
      join
      wait_count = 0;
      while (board.expected_rounds.size() != 0 && wait_count < 2000) begin
         @(posedge clock);
         wait_count++;
      end
      repeat (5) @(posedge clock);
      if (board.errors == 0 && board.expected_rounds.size() == 0)
         $display("** aes_encrypt_round: PASSED **");
      else
         $display("** aes_encrypt_round: FAILED **");
      $finish;
   end
endmodule
